// ----- sv/mam_pkg.sv -----
// ----------------------------------------------------------------------------
// mam_pkg
// Shared constants, register codes and types for the matrix add/sub/multiply
// core.
// ----------------------------------------------------------------------------
`default_nettype none

package mam_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int MODE_W     = 2;
  localparam int DIMREG_W   = 4;
  localparam int CLAMP_W    = 5;   // clamped dimension, up to 15
  localparam int ELEM_W     = 16;  // Q8.8
  localparam int SUM_W      = ELEM_W + 1;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int RES_W      = 40;  // Q24.16
  localparam int FRAC_SHIFT = 8;   // Q9.8 sum to Q24.16
  localparam int ROWCOL_W   = 3;
  localparam int OUT_DEPTH  = 4;   // result FIFO entries
  localparam int JOBQ_DEPTH = 2;   // one entry per buffer bank

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd4;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

  localparam logic [MODE_W-1:0]   MODE_RESET = MODE_MUL;
  localparam logic [DIMREG_W-1:0] DIM_RESET  = 4'd1;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [DIMREG_W-1:0] rows_a;
    logic [DIMREG_W-1:0] cols_a;
    logic [DIMREG_W-1:0] rows_b;
    logic [DIMREG_W-1:0] cols_b;
  } cfg_t;

  // one finished load, waiting for the compute side
  typedef struct packed {
    cfg_t cfg;
    logic bank;
  } job_t;

  typedef struct packed {
    logic signed [RES_W-1:0] element_out;
    logic [ROWCOL_W-1:0]     out_row;
    logic [ROWCOL_W-1:0]     out_col;
    logic                    mismatch;
    logic                    last;
  } res_t;

  // zero counts as 1, anything above max_dim counts as max_dim
  function automatic logic [CLAMP_W-1:0] clamp_dim(input logic [DIMREG_W-1:0] v,
                                                   input int unsigned max_dim);
    logic [CLAMP_W-1:0] r;
    if (v == '0) begin
      r = CLAMP_W'(1);
    end else if (32'(v) > max_dim) begin
      r = CLAMP_W'(max_dim);
    end else begin
      r = CLAMP_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/mam_in_if.sv -----
// ----------------------------------------------------------------------------
// mam_in_if
// Element request channel: one signed Q8.8 matrix element per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mam_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [mam_pkg::ELEM_W-1:0] element_in;

  modport source (output valid, output element_in, input ready);
  modport sink   (input valid, input element_in, output ready);
endinterface

`default_nettype wire

// ----- sv/mam_out_if.sv -----
// ----------------------------------------------------------------------------
// mam_out_if
// Result request channel: one result element with its position and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface mam_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mam_pkg::RES_W-1:0]   element_out;
  logic [mam_pkg::ROWCOL_W-1:0]       out_row;
  logic [mam_pkg::ROWCOL_W-1:0]       out_col;
  logic                               mismatch;
  logic                               last;

  modport source (output valid, output element_out, output out_row, output out_col,
                  output mismatch, output last, input ready);
  modport sink   (input valid, input element_out, input out_row, input out_col,
                  input mismatch, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/mam_ram.sv -----
// ----------------------------------------------------------------------------
// mam_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/mam_jobq.sv -----
// ----------------------------------------------------------------------------
// mam_jobq
// Two-entry queue of finished loads between the load side and the compute
// side. An entry stays until its last read or its mismatch word is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_jobq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mam_pkg::job_t  push_job,
  output logic           full,
  output logic           head_valid,
  output mam_pkg::job_t  head_job,
  input  logic           pop
);

  localparam int PW = $clog2(mam_pkg::JOBQ_DEPTH);
  localparam int CW = $clog2(mam_pkg::JOBQ_DEPTH + 1);

  mam_pkg::job_t entries [mam_pkg::JOBQ_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;

  assign full       = (cnt == CW'(mam_pkg::JOBQ_DEPTH));
  assign head_valid = (cnt != '0);
  assign head_job   = entries[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        entries[wp] <= push_job;
        wp          <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + CW'(push) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- sv/mam_front.sv -----
// ----------------------------------------------------------------------------
// mam_front
// Load side: takes elements, works out which matrix and which entry each one
// lands in, writes it into the current buffer bank and queues the run when
// A and B are complete.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_front #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mam_pkg::cfg_t                       cfg,
  mam_in_if.sink                              elem,
  input  logic                                jq_full,
  output logic                                push,
  output mam_pkg::job_t                       push_job,
  output logic                                wr_a,
  output logic                                wr_b,
  output logic [$clog2(MAX_DIM*MAX_DIM):0]    waddr,
  output logic [mam_pkg::ELEM_W-1:0]          wdata
);

  localparam int DV_W  = $clog2(MAX_DIM + 1);
  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int N_W   = $clog2(MAX_DIM * MAX_DIM);
  localparam int NA_W  = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int LC_W  = $clog2(2 * MAX_DIM * MAX_DIM + 1);
  localparam int K     = N_W + DV_W;   // reciprocal scale, exact for n < MAX_DIM^2
  localparam int RC_W  = K + 1;
  localparam int QP_W  = N_W + RC_W;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_WR} state_t;

  state_t                   state;
  logic [LC_W-1:0]          lc;
  logic                     wbank;
  logic [mam_pkg::ELEM_W-1:0] e_q;
  logic                     sel_b_q;
  logic                     wr_ok_q;
  logic                     done_q;
  logic [N_W-1:0]           n_q;
  logic [DV_W-1:0]          d_q;
  logic [DIM_W-1:0]         q_q;
  mam_pkg::cfg_t            cfg_q;

  logic [DV_W-1:0]  ra, ca, rb, cb, d_sel;
  logic [NA_W-1:0]  na, nb;
  logic [LC_W-1:0]  total, off_b, lc_inc;
  logic             in_a, wr_ok, done, accept;
  logic [N_W-1:0]   n_sel;
  logic [QP_W-1:0]  qprod;
  logic [N_W-1:0]   rem, idx;
  logic [RC_W-1:0]  recip_tab [MAX_DIM + 1];

  // ceil(2^K / d) for each possible column count
  assign recip_tab[0] = '0;
  for (genvar g = 1; g <= MAX_DIM; g++) begin : g_recip
    localparam int unsigned RV = ((1 << K) + g - 1) / g;
    assign recip_tab[g] = RC_W'(RV);
  end

  assign ra = DV_W'(mam_pkg::clamp_dim(cfg.rows_a, MAX_DIM));
  assign ca = DV_W'(mam_pkg::clamp_dim(cfg.cols_a, MAX_DIM));
  assign rb = DV_W'(mam_pkg::clamp_dim(cfg.rows_b, MAX_DIM));
  assign cb = DV_W'(mam_pkg::clamp_dim(cfg.cols_b, MAX_DIM));

  assign na     = NA_W'(ra) * NA_W'(ca);
  assign nb     = NA_W'(rb) * NA_W'(cb);
  assign total  = LC_W'(na) + LC_W'(nb);
  assign in_a   = (lc < LC_W'(na));
  assign off_b  = lc - LC_W'(na);
  assign wr_ok  = in_a || (off_b < LC_W'(nb));
  assign n_sel  = in_a ? N_W'(lc) : N_W'(off_b);
  assign d_sel  = in_a ? ca : cb;
  assign lc_inc = lc + 1'b1;
  assign done   = (lc_inc >= total);

  assign elem.ready = (state == F_IDLE) && !jq_full;
  assign accept     = elem.valid && elem.ready;

  // quotient by reciprocal, then remainder, then row-stride address
  assign qprod = QP_W'(n_q) * QP_W'(recip_tab[d_q]);
  assign rem   = n_q - N_W'(q_q) * N_W'(d_q);
  assign idx   = N_W'(q_q) * N_W'(MAX_DIM) + rem;

  assign wr_a     = (state == F_WR) && wr_ok_q && !sel_b_q;
  assign wr_b     = (state == F_WR) && wr_ok_q && sel_b_q;
  assign waddr    = {wbank, idx};
  assign wdata    = e_q;
  assign push     = (state == F_WR) && done_q;
  assign push_job = '{cfg: cfg_q, bank: wbank};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      lc    <= '0;
      wbank <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            e_q     <= elem.element_in;
            sel_b_q <= !in_a;
            wr_ok_q <= wr_ok;
            done_q  <= done;
            n_q     <= n_sel;
            d_q     <= d_sel;
            cfg_q   <= cfg;
            lc      <= done ? '0 : lc_inc;
            state   <= F_DIV;
          end
        end
        F_DIV: begin
          q_q   <= DIM_W'(qprod >> K);
          state <= F_WR;
        end
        F_WR: begin
          if (done_q) begin
            wbank <= ~wbank;
          end
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/mam_back.sv -----
// ----------------------------------------------------------------------------
// mam_back
// Compute side: walks the result matrix of the queued run, reads A and B and
// adds, subtracts or multiplies in a short pipeline into a small result FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_back #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  mam_pkg::job_t                     head_job,
  output logic                              pop,
  output logic [$clog2(MAX_DIM*MAX_DIM):0]  raddr_a,
  output logic [$clog2(MAX_DIM*MAX_DIM):0]  raddr_b,
  input  logic [mam_pkg::ELEM_W-1:0]        rdata_a,
  input  logic [mam_pkg::ELEM_W-1:0]        rdata_b,
  mam_out_if.source                         result
);

  localparam int DV_W  = $clog2(MAX_DIM + 1);
  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int N_W   = $clog2(MAX_DIM * MAX_DIM);
  localparam int HW    = $clog2(mam_pkg::OUT_DEPTH + 1);
  localparam int FP_W  = $clog2(mam_pkg::OUT_DEPTH);

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_MIS} state_t;

  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             mul;
    logic             sub;
    logic             last_el;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } tag_t;

  state_t            state;
  logic [DIM_W-1:0]  i, j, k;
  logic              s1_v, s2_v;
  tag_t              s1_tag, s2_tag;
  logic signed [mam_pkg::RES_W-1:0] s2_val;
  logic signed [mam_pkg::RES_W-1:0] acc;
  logic [HW-1:0]     held;     // elements started but not yet taken by the sink

  mam_pkg::res_t     fifo [mam_pkg::OUT_DEPTH];
  logic [FP_W-1:0]   wp, rp;
  logic [HW-1:0]     cnt;

  logic [DV_W-1:0]   ra, ca, rb, cb, ni, nj, nk;
  logic [DIM_W-1:0]  lim_i, lim_j, lim_k;
  logic              is_mul, is_addsub, shape_ok;
  logic              issue, issue_first, final_issue, mis_push, res_push, out_pop;
  logic [N_W-1:0]    a_idx, b_idx;
  tag_t              tag_in;

  logic signed [mam_pkg::ELEM_W-1:0] a_s, b_s;
  logic signed [mam_pkg::PROD_W-1:0] prod;
  logic signed [mam_pkg::SUM_W-1:0]  sum;
  logic signed [mam_pkg::RES_W-1:0]  val;
  logic signed [mam_pkg::RES_W-1:0]  acc_next;
  mam_pkg::res_t                     res_in;

  assign ra = DV_W'(mam_pkg::clamp_dim(head_job.cfg.rows_a, MAX_DIM));
  assign ca = DV_W'(mam_pkg::clamp_dim(head_job.cfg.cols_a, MAX_DIM));
  assign rb = DV_W'(mam_pkg::clamp_dim(head_job.cfg.rows_b, MAX_DIM));
  assign cb = DV_W'(mam_pkg::clamp_dim(head_job.cfg.cols_b, MAX_DIM));

  assign is_mul    = (head_job.cfg.mode == mam_pkg::MODE_MUL);
  assign is_addsub = (head_job.cfg.mode == mam_pkg::MODE_ADD) ||
                     (head_job.cfg.mode == mam_pkg::MODE_SUB);
  assign shape_ok  = (is_addsub && (ra == rb) && (ca == cb)) || (is_mul && (ca == rb));

  assign ni    = ra;
  assign nj    = is_mul ? cb : ca;
  assign nk    = is_mul ? ca : DV_W'(1);
  assign lim_i = DIM_W'(ni - DV_W'(1));
  assign lim_j = DIM_W'(nj - DV_W'(1));
  assign lim_k = DIM_W'(nk - DV_W'(1));

  // a new element only starts when a FIFO slot is reserved for it
  assign issue       = (state == B_RUN) &&
                       ((k != '0) || (held < HW'(mam_pkg::OUT_DEPTH)));
  assign issue_first = issue && (k == '0);
  assign final_issue = issue && (k == lim_k) && (j == lim_j) && (i == lim_i);

  assign a_idx   = N_W'(i) * N_W'(MAX_DIM) + N_W'(is_mul ? k : j);
  assign b_idx   = N_W'(is_mul ? k : i) * N_W'(MAX_DIM) + N_W'(j);
  assign raddr_a = {head_job.bank, a_idx};
  assign raddr_b = {head_job.bank, b_idx};

  assign tag_in = '{first:   (k == '0),
                    last_k:  (k == lim_k),
                    mul:     is_mul,
                    sub:     (head_job.cfg.mode == mam_pkg::MODE_SUB),
                    last_el: (j == lim_j) && (i == lim_i),
                    row:     i,
                    col:     j};

  // stage 1: RAM data arrives
  assign a_s  = rdata_a;
  assign b_s  = rdata_b;
  assign prod = a_s * b_s;
  assign sum  = s1_tag.sub ? mam_pkg::SUM_W'(a_s) - mam_pkg::SUM_W'(b_s)
                           : mam_pkg::SUM_W'(a_s) + mam_pkg::SUM_W'(b_s);
  assign val  = s1_tag.mul ? mam_pkg::RES_W'(prod)
                           : (mam_pkg::RES_W'(sum) <<< mam_pkg::FRAC_SHIFT);

  // stage 2: accumulate
  assign acc_next = s2_tag.first ? s2_val : acc + s2_val;
  assign res_push = s2_v && s2_tag.last_k;

  // the mismatch word waits for the pipeline to drain so it cannot collide
  assign mis_push = (state == B_MIS) && !s1_v && !s2_v &&
                    (held < HW'(mam_pkg::OUT_DEPTH));

  assign res_in = mis_push ?
                  mam_pkg::res_t'{element_out: '0, out_row: '0, out_col: '0,
                                  mismatch: 1'b1, last: 1'b1} :
                  mam_pkg::res_t'{element_out: acc_next,
                                  out_row:     mam_pkg::ROWCOL_W'(s2_tag.row),
                                  out_col:     mam_pkg::ROWCOL_W'(s2_tag.col),
                                  mismatch:    1'b0,
                                  last:        s2_tag.last_el};

  assign pop = final_issue || mis_push;

  assign result.valid       = (cnt != '0);
  assign result.element_out = fifo[rp].element_out;
  assign result.out_row     = fifo[rp].out_row;
  assign result.out_col     = fifo[rp].out_col;
  assign result.mismatch    = fifo[rp].mismatch;
  assign result.last        = fifo[rp].last;
  assign out_pop            = result.valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      held  <= '0;
      wp    <= '0;
      rp    <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          i <= '0;
          j <= '0;
          k <= '0;
          if (head_valid) begin
            state <= shape_ok ? B_RUN : B_MIS;
          end
        end
        B_RUN: begin
          if (issue) begin
            if (k == lim_k) begin
              k <= '0;
              if (j == lim_j) begin
                j <= '0;
                if (i == lim_i) begin
                  i     <= '0;
                  state <= B_IDLE;
                end else begin
                  i <= i + 1'b1;
                end
              end else begin
                j <= j + 1'b1;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        B_MIS: begin
          if (mis_push) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase

      s1_v <= issue;
      if (issue) begin
        s1_tag <= tag_in;
      end
      s2_v <= s1_v;
      if (s1_v) begin
        s2_tag <= s1_tag;
        s2_val <= val;
      end
      if (s2_v) begin
        acc <= acc_next;
      end

      if (res_push || mis_push) begin
        fifo[wp] <= res_in;
        wp       <= wp + 1'b1;
      end
      if (out_pop) begin
        rp <= rp + 1'b1;
      end
      cnt  <= cnt + HW'(res_push || mis_push) - HW'(out_pop);
      held <= held + HW'(issue_first || mis_push) - HW'(out_pop);
    end
  end

endmodule

`default_nettype wire

// ----- sv/matrix_add_sub_multiply_core.sv -----
// ----------------------------------------------------------------------------
// matrix_add_sub_multiply_core
// Loads A then B element by element, then emits A+B, A-B or A*B row-major.
//
//   channel   dir  handshake          payload
//   elem      in   valid/ready        element_in  (Q8.8)
//   result    out  valid/ready        element_out (Q24.16), out_row, out_col,
//                                     mismatch, last
//   cfg       in   cfg_we (no stall)  cfg_idx, cfg_wdata
//
// Each element is loaded in steps: accept, reciprocal divide, RAM write; the
// next element is accepted only after the write. Compute runs from a second
// buffer bank: add/sub give one result per cycle, multiply one MAC per cycle.
// A and B are double buffered, so a new load proceeds while the last run is
// still being computed; loads stall only when both banks hold open runs.
// Compute stalls when the 4-entry result FIFO is full. Reset is synchronous
// and clears control state only; buffer RAMs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_add_sub_multiply_core #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mam_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [mam_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  mam_in_if.sink                            elem,
  mam_out_if.source                         result
);

  localparam int AW        = $clog2(MAX_DIM * MAX_DIM) + 1;
  localparam int RAM_DEPTH = 2 ** AW;

  mam_pkg::cfg_t cfg;
  mam_pkg::job_t push_job, head_job;
  logic          push, jq_full, head_valid, pop;
  logic          wr_a, wr_b;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [mam_pkg::ELEM_W-1:0] wdata, rdata_a, rdata_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{mode:   mam_pkg::MODE_RESET,
               rows_a: mam_pkg::DIM_RESET,
               cols_a: mam_pkg::DIM_RESET,
               rows_b: mam_pkg::DIM_RESET,
               cols_b: mam_pkg::DIM_RESET};
    end else if (cfg_we) begin
      case (cfg_idx)
        mam_pkg::REG_MODE:   cfg.mode   <= cfg_wdata[mam_pkg::MODE_W-1:0];
        mam_pkg::REG_ROWS_A: cfg.rows_a <= cfg_wdata;
        mam_pkg::REG_COLS_A: cfg.cols_a <= cfg_wdata;
        mam_pkg::REG_ROWS_B: cfg.rows_b <= cfg_wdata;
        mam_pkg::REG_COLS_B: cfg.cols_b <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mam_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .elem     (elem),
    .jq_full  (jq_full),
    .push     (push),
    .push_job (push_job),
    .wr_a     (wr_a),
    .wr_b     (wr_b),
    .waddr    (waddr),
    .wdata    (wdata)
  );

  mam_ram #(.WIDTH(mam_pkg::ELEM_W), .DEPTH(RAM_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mam_ram #(.WIDTH(mam_pkg::ELEM_W), .DEPTH(RAM_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  mam_jobq u_jobq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (jq_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  mam_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b),
    .result     (result)
  );

endmodule

`default_nettype wire

// ----- sv/mam_checker.sv -----
// ----------------------------------------------------------------------------
// mam_checker
// Port-level checks for the matrix core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mam_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mam_pkg::RES_W-1:0]     element_out,
  input logic [mam_pkg::ROWCOL_W-1:0]  out_row,
  input logic [mam_pkg::ROWCOL_W-1:0]  out_col,
  input logic                          out_mismatch,
  input logic                          out_last
);

  logic seen_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_in <= 1'b0;
    end else if (in_valid && in_ready) begin
      seen_in <= 1'b1;
    end
  end

  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result request right after reset");

  a_no_result_without_input: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seen_in)
    else $error("result request before any element was taken");

  a_mismatch_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_mismatch |->
      out_last && (out_row == '0) && (out_col == '0) && (element_out == '0))
    else $error("mismatch result carries data or is not last");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(element_out) && $stable(out_row) && $stable(out_col) &&
      $stable(out_mismatch) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind matrix_add_sub_multiply_core mam_checker u_mam_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (elem.valid),
  .in_ready     (elem.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .element_out  (result.element_out),
  .out_row      (result.out_row),
  .out_col      (result.out_col),
  .out_mismatch (result.mismatch),
  .out_last     (result.last)
);

`default_nettype wire
